>>> design/txda_pkg.sv
`default_nettype none

package txda_pkg;

  // Block sizing
  localparam int NUM_IDS           = 32;
  localparam int AGGR_BUFFER_BYTES = 16384;
  localparam int NUM_LINKS         = 16;
  localparam int NUM_CLASSES       = 4;

  // Derived widths
  localparam int CNT_W     = $clog2(NUM_IDS + 1);
  localparam int CTR_DEPTH = NUM_CLASSES + NUM_LINKS;
  localparam int CA_W      = (CTR_DEPTH > 1) ? $clog2(CTR_DEPTH) : 1;

  // Fixed constants of the allocator
  localparam int          BLOCK_BYTES  = 268;
  localparam int          BLOCK_MARGIN = 1;
  localparam logic [7:0]  DESCR_RESET  = 8'd32;
  localparam logic [11:0] MAX12        = 12'hFFF;
  localparam logic [15:0] MAX16        = 16'hFFFF;

  // Reciprocal for divide by BLOCK_BYTES: exact for dividends below 2^16
  localparam int          BLK_SHIFT = 32;
  localparam logic [23:0] BLK_RECIP =
    24'(((64'd1 << BLK_SHIFT) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));

  // Request codes
  localparam logic [1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [1:0] FUNC_FREE   = 2'd1;
  localparam logic [1:0] FUNC_CREDIT = 2'd2;

  // Result codes
  localparam logic [2:0] ST_ALLOC     = 3'd0;
  localparam logic [2:0] ST_BUF_FULL  = 3'd1;
  localparam logic [2:0] ST_NO_ID     = 3'd2;
  localparam logic [2:0] ST_NO_BLOCKS = 3'd3;
  localparam logic [2:0] ST_DONE      = 3'd4;
  localparam logic [2:0] ST_IGNORED   = 3'd5;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CLS  = 2'd1;
  localparam logic [1:0] S_LNK  = 2'd2;

endpackage

`default_nettype wire

>>> design/tx_descriptor_block_allocator.sv
`default_nettype none

// Transmit descriptor id and memory block allocator. Free, credit, refused and
// unknown requests do not leave the idle state; a successful allocation keeps
// the block busy through S_CLS and S_LNK, as the per-class and per-link packet
// counters sit in one counter memory with a registered read and are updated one
// after the other (class entry, then link entry). A new request is taken only
// when the previous beat on the result side has been taken or is being taken in
// the same cycle. The counter memory comes out of reset cleared through
// per-entry valid bits, so no clearing pass is run. descriptor_bytes is to be
// written via cfg_we/cfg_wdata only while idle; the block does not enforce it.
module tx_descriptor_block_allocator import txda_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [13:0] frame_len,
  input  wire logic [14:0] fill_offset,
  input  wire logic [1:0]  access_class,
  input  wire logic [3:0]  link_id,
  input  wire logic        link_active,
  input  wire logic        reinit_watchdog,
  input  wire logic [4:0]  release_id,
  input  wire logic [11:0] credit_blocks,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [4:0]       tx_id,
  output logic [11:0]      blocks_used,
  output logic             rearm_watchdog,
  output logic [5:0]       ids_in_use,
  output logic [11:0]      blocks_free
);

  // Architectural state
  logic [7:0]         desc_bytes;
  logic [NUM_IDS-1:0] id_map;
  logic [CNT_W-1:0]   ids_cnt;
  logic [11:0]        pool;
  logic [11:0]        outst;

  // Counter memory and its valid bits
  logic [15:0]          ctr_mem [CTR_DEPTH];
  logic [CTR_DEPTH-1:0] ctr_vld;
  logic [CA_W-1:0]      rd_addr;
  logic [15:0]          rd_data;
  logic                 rd_vld;
  logic                 wr_en;
  logic [CA_W-1:0]      wr_addr;
  logic [15:0]          wr_data;
  logic [15:0]          ctr_val;

  // Sequencer
  logic [1:0]      state, state_next;
  logic [CA_W-1:0] cls_addr, lnk_addr;
  logic            cls_en, lnk_en;

  logic in_fire;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  // Allocation datapath
  logic [14:0]        frame_bytes;
  logic [17:0]        sum_off;
  logic               buf_full;
  logic [NUM_IDS-1:0] free_oh;
  logic               id_found;
  logic [6:0]         id_enc;
  logic [14:0]        rnd_len;
  logic [39:0]        prod;
  logic [5:0]         quot;
  logic [6:0]         blocks;
  logic               blk_ok;
  logic [12:0]        outst_sum;
  logic [12:0]        pool_sum;
  logic [NUM_IDS-1:0] rel_oh;
  logic               rel_hit;
  logic               alloc_ok;
  logic               cls_in, lnk_in;

  assign frame_bytes = 15'(frame_len) + 15'(desc_bytes);
  assign sum_off     = 18'(fill_offset) + 18'(frame_bytes);
  assign buf_full    = sum_off > 18'(AGGR_BUFFER_BYTES);

  // Lowest clear id as a one-hot vector
  assign free_oh  = ~id_map & (id_map + NUM_IDS'(1));
  assign id_found = |free_oh;

  always_comb begin
    id_enc = 7'd0;
    for (int i = 0; i < NUM_IDS; i++) begin
      if (free_oh[i]) id_enc = id_enc | 7'(i);
    end
  end

  // ceil(frame_bytes / BLOCK_BYTES) via reciprocal multiply
  assign rnd_len = frame_bytes + 15'(BLOCK_BYTES - 1);
  assign prod    = 40'(rnd_len) * 40'(BLK_RECIP);
  assign quot    = prod[BLK_SHIFT+5:BLK_SHIFT];
  assign blocks  = 7'(quot) + 7'(BLOCK_MARGIN);
  assign blk_ok  = 12'(blocks) <= pool;

  assign outst_sum = 13'(outst) + 13'(blocks);
  assign pool_sum  = 13'(pool) + 13'(credit_blocks);

  // Release lookup
  always_comb begin
    for (int i = 0; i < NUM_IDS; i++) begin
      rel_oh[i] = (7'(i) == 7'(release_id));
    end
  end
  assign rel_hit = |(rel_oh & id_map);

  assign alloc_ok = (func == FUNC_ALLOC) && !buf_full && id_found && blk_ok;
  assign cls_in   = 4'(access_class) < 4'(NUM_CLASSES);
  assign lnk_in   = link_active && (7'(link_id) < 7'(NUM_LINKS));

  // Next state of the allocator registers and the result beat
  logic [NUM_IDS-1:0] id_map_next;
  logic [CNT_W-1:0]   ids_cnt_next;
  logic [11:0]        pool_next, outst_next;
  logic [2:0]         st_next;
  logic [4:0]         id_next;
  logic [11:0]        used_next;
  logic               rearm_next;

  always_comb begin
    id_map_next  = id_map;
    ids_cnt_next = ids_cnt;
    pool_next    = pool;
    outst_next   = outst;
    st_next      = ST_IGNORED;
    id_next      = 5'd0;
    used_next    = 12'd0;
    rearm_next   = 1'b0;
    case (func)
      FUNC_ALLOC: begin
        if (buf_full) begin
          st_next = ST_BUF_FULL;
        end else if (!id_found) begin
          st_next = ST_NO_ID;
        end else if (!blk_ok) begin
          st_next = ST_NO_BLOCKS;
        end else begin
          st_next      = ST_ALLOC;
          id_map_next  = id_map | free_oh;
          ids_cnt_next = ids_cnt + CNT_W'(1);
          pool_next    = pool - 12'(blocks);
          outst_next   = (outst_sum > 13'(MAX12)) ? MAX12 : outst_sum[11:0];
          id_next      = id_enc[4:0];
          used_next    = 12'(blocks);
          rearm_next   = (outst == 12'd0) || reinit_watchdog;
        end
      end
      FUNC_FREE: begin
        if (rel_hit) begin
          st_next     = ST_DONE;
          id_map_next = id_map & ~rel_oh;
          if (ids_cnt != CNT_W'(0)) ids_cnt_next = ids_cnt - CNT_W'(1);
        end
      end
      FUNC_CREDIT: begin
        st_next    = ST_DONE;
        pool_next  = (pool_sum > 13'(MAX12)) ? MAX12 : pool_sum[11:0];
        outst_next = (outst > credit_blocks) ? outst - credit_blocks : 12'd0;
      end
      default: begin
        st_next = ST_IGNORED;
      end
    endcase
  end

  // Allocator registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_bytes <= DESCR_RESET;
      id_map     <= '0;
      ids_cnt    <= '0;
      pool       <= 12'd0;
      outst      <= 12'd0;
    end else begin
      if (cfg_we) desc_bytes <= cfg_wdata;
      if (in_fire) begin
        id_map  <= id_map_next;
        ids_cnt <= ids_cnt_next;
        pool    <= pool_next;
        outst   <= outst_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status         <= st_next;
      tx_id          <= id_next;
      blocks_used    <= used_next;
      rearm_watchdog <= rearm_next;
      ids_in_use     <= 6'(ids_cnt_next);
      blocks_free    <= pool_next;
    end
  end

  // Counter update sequencer: class entry first, then link entry
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_fire && alloc_ok) state_next = S_CLS;
      S_CLS:  state_next = S_LNK;
      S_LNK:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cls_en <= 1'b0;
      lnk_en <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        cls_en <= alloc_ok && cls_in;
        lnk_en <= alloc_ok && lnk_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cls_addr <= CA_W'(access_class);
      lnk_addr <= CA_W'(NUM_CLASSES) + CA_W'(link_id);
    end
  end

  // Counter memory port control
  assign rd_addr = (state == S_IDLE) ? CA_W'(access_class) : lnk_addr;
  assign ctr_val = rd_vld ? rd_data : 16'd0;
  assign wr_data = (ctr_val == MAX16) ? ctr_val : ctr_val + 16'd1;
  assign wr_addr = (state == S_CLS) ? cls_addr : lnk_addr;
  assign wr_en   = ((state == S_CLS) && cls_en) || ((state == S_LNK) && lnk_en);

  always_ff @(posedge clk) begin
    rd_data <= ctr_mem[rd_addr];
    if (wr_en) ctr_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= ctr_vld[rd_addr];
      if (wr_en) ctr_vld[wr_addr] <= 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  // Id count tracks the bitmap population
  a_cnt_map: assert property (@(posedge clk) disable iff (rst)
    32'(ids_cnt) == 32'($countones(id_map)))
    else $error("id count does not match id bitmap");

  // A successful allocation starts the counter update
  a_alloc_seq: assert property (@(posedge clk) disable iff (rst)
    (in_fire && alloc_ok) |=> (state == S_CLS))
    else $error("counter update did not start after allocation");

  // Every accepted request leaves a result beat
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted request produced no result");

  // Class and link writes never hit the same counter entry
  a_addr_split: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLS) && cls_en && lnk_en |-> (cls_addr != lnk_addr))
    else $error("class and link counters overlap");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
module tb_top;
  import txda_pkg::*;

  // func 3 has no code in the package; the block must ignore it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [1:0]  func;
    logic [13:0] frame_len;
    logic [14:0] fill_offset;
    logic [1:0]  access_class;
    logic [3:0]  link_id;
    logic        link_active;
    logic        reinit_watchdog;
    logic [4:0]  release_id;
    logic [11:0] credit_blocks;
  } tx_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  tx_id;
    logic [11:0] blocks_used;
    logic        rearm_watchdog;
    logic [5:0]  ids_in_use;
    logic [11:0] blocks_free;
  } tx_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  tx_req_t     drv_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  rsp_status;
  logic [4:0]  rsp_tx_id;
  logic [11:0] rsp_blocks_used;
  logic        rsp_rearm;
  logic [5:0]  rsp_ids_in_use;
  logic [11:0] rsp_blocks_free;
  tx_rsp_t     got;

  assign got = {rsp_status, rsp_tx_id, rsp_blocks_used, rsp_rearm, rsp_ids_in_use,
                rsp_blocks_free};

  always #1 clk = ~clk;

  tx_descriptor_block_allocator i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (drv_req.func),
    .frame_len       (drv_req.frame_len),
    .fill_offset     (drv_req.fill_offset),
    .access_class    (drv_req.access_class),
    .link_id         (drv_req.link_id),
    .link_active     (drv_req.link_active),
    .reinit_watchdog (drv_req.reinit_watchdog),
    .release_id      (drv_req.release_id),
    .credit_blocks   (drv_req.credit_blocks),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (rsp_status),
    .tx_id           (rsp_tx_id),
    .blocks_used     (rsp_blocks_used),
    .rearm_watchdog  (rsp_rearm),
    .ids_in_use      (rsp_ids_in_use),
    .blocks_free     (rsp_blocks_free)
  );

  // allocator shadow state
  logic [7:0]         descr_size = DESCR_RESET;
  logic [NUM_IDS-1:0] id_busy = '0;
  int                 ids_taken = 0;
  int                 pool_left = 0;
  int                 blocks_owed = 0;
  int                 class_frames [NUM_CLASSES];
  int                 link_frames [NUM_LINKS];

  tx_req_t req_backlog [$];
  tx_rsp_t predicted_rsp [$];
  tx_rsp_t want;

  // run control, written with nonblocking assignments from the sequence and the ready driver
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit send_pause = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // bookkeeping
  int errors = 0;
  int reqs_taken = 0;
  int rsps_seen = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;
  int status_seen [8];

  initial begin
    foreach (class_frames[i]) class_frames[i] = 0;
    foreach (link_frames[i]) link_frames[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  end

  // next state and answer of the allocator for one request
  function automatic tx_rsp_t allocate_or_release(tx_req_t r);
    tx_rsp_t rsp;
    int      total;
    int      blocks;
    int      id;
    bit      found;
    rsp = '0;
    rsp.status = ST_IGNORED;
    case (r.func)
      FUNC_ALLOC: begin
        total = int'(r.frame_len) + int'(descr_size);
        if (int'(r.fill_offset) + total > AGGR_BUFFER_BYTES) begin
          rsp.status = ST_BUF_FULL;
        end else begin
          found = 1'b0;
          id = 0;
          // lowest clear id wins
          for (int i = NUM_IDS - 1; i >= 0; i--) begin
            if (!id_busy[i]) begin
              found = 1'b1;
              id = i;
            end
          end
          blocks = (total + BLOCK_BYTES - 1) / BLOCK_BYTES + BLOCK_MARGIN;
          if (!found) begin
            rsp.status = ST_NO_ID;
          end else if (blocks <= pool_left) begin
            rsp.rearm_watchdog = (blocks_owed == 0) || r.reinit_watchdog;
            id_busy[id] = 1'b1;
            ids_taken++;
            pool_left -= blocks;
            blocks_owed = (blocks_owed + blocks > int'(MAX12)) ? int'(MAX12)
                                                               : blocks_owed + blocks;
            if (int'(r.access_class) < NUM_CLASSES &&
                class_frames[r.access_class] < int'(MAX16))
              class_frames[r.access_class]++;
            if (r.link_active && int'(r.link_id) < NUM_LINKS &&
                link_frames[r.link_id] < int'(MAX16))
              link_frames[r.link_id]++;
            rsp.status = ST_ALLOC;
            rsp.tx_id = id[4:0];
            rsp.blocks_used = blocks[11:0];
          end else begin
            rsp.status = ST_NO_BLOCKS;
          end
        end
      end
      FUNC_FREE: begin
        if (int'(r.release_id) < NUM_IDS && id_busy[r.release_id]) begin
          id_busy[r.release_id] = 1'b0;
          if (ids_taken > 0) ids_taken--;
          rsp.status = ST_DONE;
        end
      end
      FUNC_CREDIT: begin
        pool_left = (pool_left + int'(r.credit_blocks) > int'(MAX12)) ? int'(MAX12)
                    : pool_left + int'(r.credit_blocks);
        blocks_owed = (blocks_owed > int'(r.credit_blocks))
                      ? blocks_owed - int'(r.credit_blocks) : 0;
        rsp.status = ST_DONE;
      end
      default: ;
    endcase
    rsp.ids_in_use = ids_taken[5:0];
    rsp.blocks_free = pool_left[11:0];
    return rsp;
  endfunction

  function automatic tx_req_t mk_req(logic [1:0] f, int len, int off, int cls, int lnk,
                                     bit act, bit reinit, int rel, int credit);
    tx_req_t r;
    r.func = f;
    r.frame_len = len[13:0];
    r.fill_offset = off[14:0];
    r.access_class = cls[1:0];
    r.link_id = lnk[3:0];
    r.link_active = act;
    r.reinit_watchdog = reinit;
    r.release_id = rel[4:0];
    r.credit_blocks = credit[11:0];
    return r;
  endfunction

  // mostly well-formed traffic: fitting frames, frees of low ids, refills
  function automatic tx_req_t rand_req();
    tx_req_t     r;
    logic [63:0] raw;
    int          pick;
    int          sel;
    raw = {$urandom, $urandom};
    r = raw[$bits(tx_req_t)-1:0];
    pick = $urandom_range(99);
    sel = $urandom_range(9);
    if (pick < 50) begin
      r.func = FUNC_ALLOC;
      if (sel < 7) r.frame_len = 14'($urandom_range(1500));
      else if (sel < 9) r.frame_len = 14'($urandom_range(16383));
      else r.frame_len = $urandom_range(1) ? 14'd16383 : 14'd0;
      sel = $urandom_range(9);
      if (sel < 7) r.fill_offset = 15'($urandom_range(4000));
      else if (sel < 9) r.fill_offset = 15'($urandom_range(AGGR_BUFFER_BYTES));
    end else if (pick < 78) begin
      r.func = FUNC_FREE;
      if (sel < 6) r.release_id = 5'($urandom_range(7));
    end else if (pick < 95) begin
      r.func = FUNC_CREDIT;
      if (sel < 4) r.credit_blocks = 12'($urandom_range(60));
      else if (sel < 8) r.credit_blocks = 12'($urandom_range(800));
      else if (sel == 8) r.credit_blocks = MAX12;
    end else begin
      r.func = FUNC_UNUSED;
    end
    return r;
  endfunction

  function automatic string rsp_text(tx_rsp_t r);
    return $sformatf("st=%0d id=%0d used=%0d rearm=%0d ids=%0d free=%0d", r.status,
                     r.tx_id, r.blocks_used, r.rearm_watchdog, r.ids_in_use,
                     r.blocks_free);
  endfunction

  task automatic note_failure(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // request driver: a beat stays up until taken, then the next one is pulled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_rsp.push_back(allocate_or_release(drv_req));
        reqs_taken++;
      end
      if (!in_valid || in_ready) begin
        if (req_backlog.size() != 0 && !send_pause &&
            $urandom_range(99) >= send_idle_pct) begin
          drv_req <= req_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side ready: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor: compare each beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      rsps_seen++;
      status_seen[got.status]++;
      if (predicted_rsp.size() == 0) begin
        note_failure({"result with nothing predicted: ", rsp_text(got)});
      end else begin
        want = predicted_rsp.pop_front();
        if (got !== want)
          note_failure({"expected ", rsp_text(want), " got ", rsp_text(got)});
      end
    end
  end

  // watchdog on cycles without any useful beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) ||
        (out_valid && out_ready && predicted_rsp.size() != 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic drain();
    while (req_backlog.size() != 0 || in_valid || predicted_rsp.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_descr(logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    descr_size = v;
    cfg_writes++;
  endtask

  task automatic run_phase(int send_pct, int stall_pct, int n);
    send_idle_pct <= send_pct;
    recv_stall_pct <= stall_pct;
    repeat (n) req_backlog.push_back(rand_req());
    drain();
  endtask

  // test sequence
  initial begin
    int mark;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed corners with the reset descriptor size
    req_backlog.push_back(mk_req(FUNC_ALLOC, 0, 0, 0, 0, 1, 0, 0, 0));
    req_backlog.push_back(mk_req(FUNC_UNUSED, 16383, 16384, 3, 15, 1, 1, 31, 4095));
    req_backlog.push_back(mk_req(FUNC_FREE, 0, 0, 0, 0, 0, 0, 0, 0));
    req_backlog.push_back(mk_req(FUNC_FREE, 0, 0, 0, 0, 0, 0, 31, 0));
    req_backlog.push_back(mk_req(FUNC_CREDIT, 0, 0, 0, 0, 0, 0, 0, 0));
    req_backlog.push_back(mk_req(FUNC_CREDIT, 0, 0, 0, 0, 0, 0, 0, 4095));
    req_backlog.push_back(mk_req(FUNC_CREDIT, 0, 0, 0, 0, 0, 0, 0, 4095));
    req_backlog.push_back(mk_req(FUNC_ALLOC, 0, 0, 0, 0, 1, 0, 0, 0));
    req_backlog.push_back(mk_req(FUNC_ALLOC, 16383, 0, 1, 2, 1, 0, 0, 0));
    // frame plus descriptor fills the aggregation buffer exactly
    req_backlog.push_back(mk_req(FUNC_ALLOC, 16352, 0, 3, 15, 1, 1, 0, 0));
    req_backlog.push_back(mk_req(FUNC_ALLOC, 0, 16384, 0, 0, 1, 0, 0, 0));
    req_backlog.push_back(mk_req(FUNC_ALLOC, 0, 32767, 0, 0, 1, 0, 0, 0));
    req_backlog.push_back(mk_req(FUNC_ALLOC, 1500, 14000, 2, 7, 0, 0, 0, 0));
    req_backlog.push_back(mk_req(FUNC_FREE, 0, 0, 0, 0, 0, 0, 1, 0));
    req_backlog.push_back(mk_req(FUNC_FREE, 0, 0, 0, 0, 0, 0, 1, 0));
    // total length right on and just past a block boundary
    req_backlog.push_back(mk_req(FUNC_ALLOC, 236, 0, 1, 3, 1, 0, 0, 0));
    req_backlog.push_back(mk_req(FUNC_ALLOC, 237, 0, 1, 3, 1, 0, 0, 0));
    // large credit clears the outstanding count and saturates the pool
    req_backlog.push_back(mk_req(FUNC_CREDIT, 0, 0, 0, 0, 0, 0, 0, 4000));
    req_backlog.push_back(mk_req(FUNC_ALLOC, 100, 0, 0, 9, 1, 0, 0, 0));
    req_backlog.push_back(mk_req(FUNC_FREE, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // random traffic across descriptor sizes and idling patterns
    set_descr(8'd0);
    run_phase(0, 0, 250);
    set_descr(8'd255);
    run_phase(52, 0, 250);
    set_descr(8'($urandom_range(1, 254)));
    run_phase(0, 52, 250);
    set_descr(8'd32);
    run_phase(20, 20, 250);

    // back-pressure: long receiver hold-off while the sender keeps offering
    set_descr(8'($urandom_range(255)));
    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    mark = reqs_taken;
    repeat (120) req_backlog.push_back(rand_req());
    while (reqs_taken < mark + 10) @(posedge clk);
    hold_req <= hold_req + 1;
    while (req_backlog.size() != 0) @(posedge clk);
    // sender holds until every result is back
    send_pause <= 1'b1;
    while (in_valid || predicted_rsp.size() != 0) @(posedge clk);
    send_pause <= 1'b0;
    recv_stall_pct <= 30;
    repeat (100) req_backlog.push_back(rand_req());
    drain();

    $display("covered %0d requests, %0d results, %0d descriptor size writes",
             reqs_taken, rsps_seen, cfg_writes);
    $display("outcomes: alloc %0d, buf full %0d, no id %0d, no blocks %0d, done %0d, ign %0d",
             status_seen[ST_ALLOC], status_seen[ST_BUF_FULL], status_seen[ST_NO_ID],
             status_seen[ST_NO_BLOCKS], status_seen[ST_DONE], status_seen[ST_IGNORED]);
    if (errors == 0 && predicted_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, predicted_rsp.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/txda_pkg.sv
design/tx_descriptor_block_allocator.sv
test/tb_top.sv
